>>> rtl/rtp_frame_reassembly_tracker_assert.svh
// Assertion shorthands shared by the tracker modules.
// Each expects aclk and aresetn to be visible where it is used.
`ifndef RTP_FRAME_REASSEMBLY_TRACKER_ASSERT_SVH
`define RTP_FRAME_REASSEMBLY_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define RTPFRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTPFRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rtpfrt_pkg.sv
package rtpfrt_pkg;

    localparam int DEF_SLOTS      = 16;
    localparam int DEF_MAX_PACKET = 65527;

    localparam int LEN_W   = 16;
    localparam int SEQ_W   = 16;
    localparam int TS_W    = 32;
    localparam int SRC_W   = 32;
    localparam int FRAME_W = 25;
    localparam int POS_W   = 26;
    localparam int CNT_W   = 16;
    localparam int FCNT_W  = 32;

    localparam logic [LEN_W-1:0]   HDR_BYTES         = 16'd12;
    localparam logic [POS_W-1:0]   POS_MAX           = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX           = {CNT_W{1'b1}};
    localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET = 25'd614400;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_SHORT        = 3'd2,
        ST_SRC_MISMATCH = 3'd3,
        ST_BEYOND       = 3'd4
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0] packet_length;
        logic             marker;
        logic [SEQ_W-1:0] seq_number;
        logic [TS_W-1:0]  timestamp;
        logic [SRC_W-1:0] source_id;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]   write_offset;
        logic [FRAME_W-1:0] chunk_offset;
        logic               seq_gap;
        logic [SEQ_W-1:0]   seq_missed;
        logic               frame_done;
        logic [CNT_W-1:0]   chunks_in_frame;
        logic               timestamp_back;
        logic [FCNT_W-1:0]  frame_count;
        logic               storage_wrapped;
    } result_t;

endpackage

>>> rtl/rtpfrt_core.sv
`include "rtp_frame_reassembly_tracker_assert.svh"

module rtpfrt_core #(
    parameter int SLOTS      = rtpfrt_pkg::DEF_SLOTS,
    parameter int MAX_PACKET = rtpfrt_pkg::DEF_MAX_PACKET,
    localparam int SLOT_W    = $clog2(SLOTS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  rtpfrt_pkg::item_t                   item,
    input  logic [rtpfrt_pkg::FRAME_W-1:0]      frame_bytes,
    output rtpfrt_pkg::result_t                 res,
    output logic [SLOT_W-1:0]                   write_slot,
    output logic [SLOT_W-1:0]                   done_slot
);

    localparam int POS_W = rtpfrt_pkg::POS_W;
    localparam int SEQ_W = rtpfrt_pkg::SEQ_W;
    localparam int CNT_W = rtpfrt_pkg::CNT_W;
    localparam int LEN_W = rtpfrt_pkg::LEN_W;
    localparam int FRAME_W = rtpfrt_pkg::FRAME_W;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(SLOTS - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    logic [SLOT_W-1:0]               store_slot_reg, store_slot_next;
    logic [POS_W-1:0]                store_position_reg, store_position_next;
    logic [SLOT_W-1:0]               frame_slot_reg, frame_slot_next;
    logic [SLOT_W-1:0]               completed_slot_reg, completed_slot_next;
    logic [rtpfrt_pkg::FCNT_W-1:0]   frames_completed_reg, frames_completed_next;
    logic                            source_locked_reg, source_locked_next;
    logic [rtpfrt_pkg::SRC_W-1:0]    locked_source_reg, locked_source_next;
    logic                            seen_packet_reg, seen_packet_next;
    logic [SEQ_W-1:0]                previous_seq_reg, previous_seq_next;
    logic [SEQ_W-1:0]                frame_start_seq_reg, frame_start_seq_next;
    logic [LEN_W-1:0]                first_chunk_size_reg, first_chunk_size_next;
    logic [CNT_W-1:0]                chunk_counter_reg, chunk_counter_next;
    logic [POS_W-1:0]                frame_bytes_used_reg, frame_bytes_used_next;
    logic [rtpfrt_pkg::TS_W-1:0]     previous_timestamp_reg, previous_timestamp_next;

    logic [LEN_W-1:0]   len_c;
    logic               room_short;
    logic [SLOT_W-1:0]  slot_a;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W:0]     pos_sum;
    logic [POS_W-1:0]   pos_b;
    logic               is_empty;
    logic               is_short;
    logic               is_foreign;
    logic               good;
    logic [LEN_W-1:0]   csize;
    logic               first_chunk;
    logic [SEQ_W-1:0]   idx;
    logic [31:0]        prod;
    logic [31:0]        off;
    logic [32:0]        off_end;
    logic               beyond;
    logic [SEQ_W-1:0]   expect_seq;
    logic               gap;
    logic [CNT_W-1:0]   cc_inc;
    logic [POS_W:0]     fbu_sum;
    logic [POS_W-1:0]   fbu_sat;
    logic               close;
    logic               ts_back;

    always_comb begin
        len_c      = (item.packet_length > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET)
                                                               : item.packet_length;
        room_short = ({1'b0, store_position_reg} + (POS_W + 1)'(MAX_PACKET))
                     > {1'b0, frame_bytes, 1'b0};
        slot_a     = room_short ? slot_inc(store_slot_reg) : store_slot_reg;
        pos_a      = room_short ? '0 : store_position_reg;
        pos_sum    = {1'b0, pos_a} + (POS_W + 1)'(len_c);
        pos_b      = pos_sum[POS_W] ? rtpfrt_pkg::POS_MAX : pos_sum[POS_W-1:0];

        is_empty   = (len_c == '0);
        is_short   = (len_c < rtpfrt_pkg::HDR_BYTES);
        is_foreign = source_locked_reg && (item.source_id != locked_source_reg);
        good       = !is_empty && !is_short && !is_foreign;
        csize      = len_c - rtpfrt_pkg::HDR_BYTES;

        // A frame's first chunk sets the chunk size and the starting sequence.
        first_chunk = (frame_bytes_used_reg == '0);
        idx         = item.seq_number - frame_start_seq_reg;
        prod        = 32'(idx) * 32'(first_chunk_size_reg);
        off         = first_chunk ? '0 : prod;
        off_end     = {1'b0, off} + 33'(csize);
        beyond      = off_end > 33'(frame_bytes);

        expect_seq = previous_seq_reg + 1'b1;
        gap        = good && seen_packet_reg && (expect_seq != item.seq_number);

        cc_inc  = (chunk_counter_reg == rtpfrt_pkg::CNT_MAX) ? rtpfrt_pkg::CNT_MAX
                                                             : chunk_counter_reg + 1'b1;
        fbu_sum = {1'b0, frame_bytes_used_reg} + (POS_W + 1)'(csize);
        fbu_sat = fbu_sum[POS_W] ? rtpfrt_pkg::POS_MAX : fbu_sum[POS_W-1:0];

        close   = good && (item.marker || beyond);
        ts_back = close && (item.timestamp < previous_timestamp_reg)
                  && (previous_timestamp_reg != '0) && (item.timestamp != '0);
    end

    always_comb begin
        priority if (is_empty) begin
            res.status = rtpfrt_pkg::ST_EMPTY;
        end else if (is_short) begin
            res.status = rtpfrt_pkg::ST_SHORT;
        end else if (is_foreign) begin
            res.status = rtpfrt_pkg::ST_SRC_MISMATCH;
        end else if (beyond) begin
            res.status = rtpfrt_pkg::ST_BEYOND;
        end else begin
            res.status = rtpfrt_pkg::ST_OK;
        end
        res.write_offset    = pos_a;
        res.chunk_offset    = (good && !beyond) ? off[FRAME_W-1:0] : '0;
        res.seq_gap         = gap;
        res.seq_missed      = gap ? (item.seq_number - expect_seq) : '0;
        res.frame_done      = close;
        res.chunks_in_frame = close ? cc_inc : '0;
        res.timestamp_back  = ts_back;
        res.frame_count     = close ? frames_completed_reg + 1'b1 : frames_completed_reg;
        res.storage_wrapped = room_short;
        write_slot          = slot_a;
        done_slot           = close ? frame_slot_reg : completed_slot_reg;
    end

    always_comb begin
        store_slot_next         = store_slot_reg;
        store_position_next     = store_position_reg;
        frame_slot_next         = frame_slot_reg;
        completed_slot_next     = completed_slot_reg;
        frames_completed_next   = frames_completed_reg;
        source_locked_next      = source_locked_reg;
        locked_source_next      = locked_source_reg;
        seen_packet_next        = seen_packet_reg;
        previous_seq_next       = previous_seq_reg;
        frame_start_seq_next    = frame_start_seq_reg;
        first_chunk_size_next   = first_chunk_size_reg;
        chunk_counter_next      = chunk_counter_reg;
        frame_bytes_used_next   = frame_bytes_used_reg;
        previous_timestamp_next = previous_timestamp_reg;
        if (advance) begin
            store_slot_next     = close ? slot_inc(slot_a) : slot_a;
            store_position_next = (is_empty || close) ? (close ? '0 : pos_a) : pos_b;
            if (!is_empty && !is_short && !source_locked_reg) begin
                source_locked_next = 1'b1;
                locked_source_next = item.source_id;
            end
            if (good) begin
                seen_packet_next  = 1'b1;
                previous_seq_next = item.seq_number;
                if (first_chunk) begin
                    first_chunk_size_next = csize;
                    frame_start_seq_next  = item.seq_number;
                end
                chunk_counter_next    = close ? '0 : cc_inc;
                frame_bytes_used_next = close ? '0 : fbu_sat;
            end
            if (close) begin
                previous_timestamp_next = item.timestamp;
                completed_slot_next     = frame_slot_reg;
                frame_slot_next         = slot_inc(frame_slot_reg);
                frames_completed_next   = frames_completed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_slot_reg         <= '0;
            store_position_reg     <= '0;
            frame_slot_reg         <= '0;
            completed_slot_reg     <= SLOT_W'(SLOTS - 1);
            frames_completed_reg   <= '0;
            source_locked_reg      <= 1'b0;
            locked_source_reg      <= '0;
            seen_packet_reg        <= 1'b0;
            previous_seq_reg       <= '0;
            frame_start_seq_reg    <= '0;
            first_chunk_size_reg   <= '0;
            chunk_counter_reg      <= '0;
            frame_bytes_used_reg   <= '0;
            previous_timestamp_reg <= '0;
        end else begin
            store_slot_reg         <= store_slot_next;
            store_position_reg     <= store_position_next;
            frame_slot_reg         <= frame_slot_next;
            completed_slot_reg     <= completed_slot_next;
            frames_completed_reg   <= frames_completed_next;
            source_locked_reg      <= source_locked_next;
            locked_source_reg      <= locked_source_next;
            seen_packet_reg        <= seen_packet_next;
            previous_seq_reg       <= previous_seq_next;
            frame_start_seq_reg    <= frame_start_seq_next;
            first_chunk_size_reg   <= first_chunk_size_next;
            chunk_counter_reg      <= chunk_counter_next;
            frame_bytes_used_reg   <= frame_bytes_used_next;
            previous_timestamp_reg <= previous_timestamp_next;
        end
    end

    `RTPFRT_ASSERT_IMPL(a_done_has_chunks, advance && close, cc_inc != '0, "closed frame with no chunks")
    `RTPFRT_ASSERT_IMPL(a_gap_nonzero, advance && gap, res.seq_missed != '0, "gap with zero missed count")
    `RTPFRT_ASSERT_NEXT(a_close_clears, advance && close, chunk_counter_reg == '0 && frame_bytes_used_reg == '0 && store_position_reg == '0, "frame state not cleared after close")
    `RTPFRT_ASSERT_NEXT(a_close_slot, advance && close, completed_slot_reg == $past(frame_slot_reg), "completed slot not taken from frame slot")

endmodule

>>> rtl/rtp_frame_reassembly_tracker.sv
// RTP frame reassembly tracker: one transfer on the s_ channel carries the length and header
// fields of one received RTP packet, and one transfer on the m_ channel returns where that
// packet was stored (slot and byte offset in a ring of SLOTS slots of 2*frame_bytes bytes),
// its status, its chunk offset within the frame, sequence-gap information and, when the packet
// closes a frame (marker set or chunk past the frame end), the frame's slot, chunk count and
// timestamp check. The block takes one packet per clock cycle unless a side stalls; a result is
// registered on its way out: the packet sits in an input register, and the tracking state and
// the result register update together when the packet advances, so one chunk-offset multiply and
// compare sits on the per-packet state loop. Either side may stall freely; a waiting result
// does not stop the next packet entering the input register. Write frame_bytes through
// cfg_wr_en/cfg_wr_data only while no packet is in flight; it resets to 614400.
module rtp_frame_reassembly_tracker #(
    parameter int SLOTS      = rtpfrt_pkg::DEF_SLOTS,
    parameter int MAX_PACKET = rtpfrt_pkg::DEF_MAX_PACKET,
    localparam int SLOT_W    = $clog2(SLOTS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [rtpfrt_pkg::FRAME_W-1:0]      cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rtpfrt_pkg::LEN_W-1:0]        s_packet_length,
    input  logic                                s_marker,
    input  logic [rtpfrt_pkg::SEQ_W-1:0]        s_seq_number,
    input  logic [rtpfrt_pkg::TS_W-1:0]         s_timestamp,
    input  logic [rtpfrt_pkg::SRC_W-1:0]        s_source_id,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [SLOT_W-1:0]                   m_write_slot,
    output logic [rtpfrt_pkg::POS_W-1:0]        m_write_offset,
    output logic [rtpfrt_pkg::FRAME_W-1:0]      m_chunk_offset,
    output logic                                m_seq_gap,
    output logic [rtpfrt_pkg::SEQ_W-1:0]        m_seq_missed,
    output logic                                m_frame_done,
    output logic [SLOT_W-1:0]                   m_done_slot,
    output logic [rtpfrt_pkg::CNT_W-1:0]        m_chunks_in_frame,
    output logic                                m_timestamp_back,
    output logic [rtpfrt_pkg::FCNT_W-1:0]       m_frame_count,
    output logic                                m_storage_wrapped
);

    // Configuration register.
    logic [rtpfrt_pkg::FRAME_W-1:0] frame_bytes_reg;

    // Input register: holds one packet until the tracker can process it.
    logic               in_valid_reg, in_valid_next;
    rtpfrt_pkg::item_t  in_item_reg;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    rtpfrt_pkg::result_t  out_res_reg;
    logic [SLOT_W-1:0]    out_write_slot_reg;
    logic [SLOT_W-1:0]    out_done_slot_reg;

    logic                 in_xfer;
    logic                 advance;
    rtpfrt_pkg::result_t  core_res;
    logic [SLOT_W-1:0]    core_write_slot;
    logic [SLOT_W-1:0]    core_done_slot;

    // Advance the held packet whenever the result register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_bytes_reg <= rtpfrt_pkg::FRAME_BYTES_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                frame_bytes_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg.packet_length <= s_packet_length;
            in_item_reg.marker        <= s_marker;
            in_item_reg.seq_number    <= s_seq_number;
            in_item_reg.timestamp     <= s_timestamp;
            in_item_reg.source_id     <= s_source_id;
        end
        if (advance) begin
            out_res_reg        <= core_res;
            out_write_slot_reg <= core_write_slot;
            out_done_slot_reg  <= core_done_slot;
        end
    end

    rtpfrt_core #(
        .SLOTS      (SLOTS),
        .MAX_PACKET (MAX_PACKET)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .frame_bytes (frame_bytes_reg),
        .res         (core_res),
        .write_slot  (core_write_slot),
        .done_slot   (core_done_slot)
    );

    assign m_valid           = out_valid_reg;
    assign m_status          = out_res_reg.status;
    assign m_write_slot      = out_write_slot_reg;
    assign m_write_offset    = out_res_reg.write_offset;
    assign m_chunk_offset    = out_res_reg.chunk_offset;
    assign m_seq_gap         = out_res_reg.seq_gap;
    assign m_seq_missed      = out_res_reg.seq_missed;
    assign m_frame_done      = out_res_reg.frame_done;
    assign m_done_slot       = out_done_slot_reg;
    assign m_chunks_in_frame = out_res_reg.chunks_in_frame;
    assign m_timestamp_back  = out_res_reg.timestamp_back;
    assign m_frame_count     = out_res_reg.frame_count;
    assign m_storage_wrapped = out_res_reg.storage_wrapped;

endmodule
